// ===== hw/rtl/rtcdu_pkg.sv =====
// ----------------------------------------------------------------------------
// rtcdu_pkg
// Shared constants and helpers for the rtc calendar to unix seconds converter.
// ----------------------------------------------------------------------------
package rtcdu_pkg;

   localparam int ByteWidth   = 8;
   localparam int NumBytes    = 6;
   localparam int ReqWidth    = ByteWidth * NumBytes;
   localparam int RspWidth    = 32;

   localparam int YearWidth   = 12;
   localparam int EraWidth    = 4;
   localparam int EraMax      = 10;
   localparam int YoeWidth    = 9;
   localparam int NumWidth    = 16;
   localparam int QuotWidth   = 14;
   localparam int YtermWidth  = 18;
   localparam int HmsWidth    = 20;
   localparam int DaysWidth   = 23;

   // byte positions inside the request word
   localparam int SecIdx  = 0;
   localparam int MinIdx  = 1;
   localparam int HourIdx = 2;
   localparam int DayIdx  = 3;
   localparam int MonIdx  = 4;
   localparam int YearIdx = 5;

   localparam logic [YearWidth-1:0]  CenturyBase  = 12'd2000;
   localparam logic [ByteWidth-1:0]  TwoDigitMax  = 8'd100;
   localparam logic [ByteWidth-1:0]  FebMonth     = 8'd2;
   localparam logic [ByteWidth-1:0]  MarchShift   = 8'd3;
   localparam logic [ByteWidth-1:0]  JanShift     = 8'd9;
   localparam logic [YearWidth-1:0]  EraYears     = 12'd400;
   localparam logic [YoeWidth-1:0]   CenturyYears = 9'd100;
   localparam logic [YoeWidth-1:0]   DaysPerYear  = 9'd365;
   localparam logic [7:0]            MonthSpan    = 8'd153;
   localparam logic [NumWidth-1:0]   MonthRound   = 16'd2;
   localparam logic [NumWidth-1:0]   RecipFive    = 16'd52429;
   localparam int                    RecipShift   = 18;
   localparam logic [17:0]           DaysPerEra   = 18'd146097;
   localparam logic [DaysWidth-1:0]  EpochShift   = 23'd719468;
   localparam logic [31:0]           SecsPerDay   = 32'd86400;
   localparam logic [11:0]           SecsPerHour  = 12'd3600;
   localparam logic [5:0]            SecsPerMin   = 6'd60;
   localparam logic [3:0]            BcdWeight    = 4'd10;

   typedef struct packed {
      logic [ByteWidth-1:0] sec;
      logic [ByteWidth-1:0] min;
      logic [ByteWidth-1:0] hour;
      logic [ByteWidth-1:0] day;
      logic [ByteWidth-1:0] mon;
      logic [ByteWidth-1:0] year;
   } cal_type;

   // packed bcd decode when bcd is set, else the raw byte passes through; bad nibbles still weighted high*10 + low
   function automatic logic [ByteWidth-1:0] decode_byte(input logic [ByteWidth-1:0] raw,
                                                         input logic bcd);
      logic [ByteWidth-1:0] hi_w;
      hi_w = {4'd0, raw[7:4]} * {4'd0, BcdWeight};
      if (bcd) begin
         return hi_w + {4'd0, raw[3:0]};
      end
      return raw;
   endfunction

endpackage

// ===== hw/rtl/rtc_date_to_unix_seconds.sv =====
// ----------------------------------------------------------------------------
// rtc_date_to_unix_seconds
// Converts one rtc calendar snapshot (bcd or binary) into unix seconds.
// ----------------------------------------------------------------------------
// throughput: one word per cycle while rsp_tready allows, six register stages each with a valid bit
// a stalled output holds only the unbroken run of full stages next to it, stages before a gap keep moving
// reset: synchronous, clears all valid bits and sets the bcd mode bit
// ----------------------------------------------------------------------------
module rtc_date_to_unix_seconds (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_data,     // values_are_bcd
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // seconds_raw, minutes_raw, hours_raw, day_raw, month_raw, year_raw
   input  logic [rtcdu_pkg::ReqWidth-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // unix_seconds
   output logic [rtcdu_pkg::RspWidth-1:0] rsp_tdata
);

   logic values_are_bcd_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

   // stage 1: decoded bytes
   rtcdu_pkg::cal_type cal_in, cal_ff;

   // stage 2
   logic [rtcdu_pkg::YearWidth-1:0] y_in, y_ff;
   logic [rtcdu_pkg::ByteWidth-1:0] mp_in, mp_ff;
   logic [rtcdu_pkg::ByteWidth-1:0] d2_ff;
   logic [rtcdu_pkg::HmsWidth-1:0]  hms_in, hms2_ff;

   // stage 3
   logic [rtcdu_pkg::EraMax-1:0]    era_hit;
   logic [rtcdu_pkg::EraWidth-1:0]  era_in, era3_ff;
   logic [rtcdu_pkg::YoeWidth-1:0]  yoe_in, yoe_ff;
   logic [rtcdu_pkg::NumWidth-1:0]  num_in, num_ff;
   logic [rtcdu_pkg::ByteWidth-1:0] d3_ff;
   logic [rtcdu_pkg::HmsWidth-1:0]  hms3_ff;

   // stage 4
   logic [31:0]                      prod_w;
   logic [2:0]                       cent_hit;
   logic [rtcdu_pkg::QuotWidth-1:0]  quot_in, quot_ff;
   logic [rtcdu_pkg::YtermWidth-1:0] yterm_in, yterm_ff;
   logic [rtcdu_pkg::EraWidth-1:0]   era4_ff;
   logic [rtcdu_pkg::ByteWidth-1:0]  d4_ff;
   logic [rtcdu_pkg::HmsWidth-1:0]   hms4_ff;

   // stage 5
   logic [rtcdu_pkg::DaysWidth-1:0] days_in, days_ff;
   logic [rtcdu_pkg::HmsWidth-1:0]  hms5_ff;

   // stage 6
   logic [31:0]                     days_ext;
   logic [rtcdu_pkg::RspWidth-1:0]  secs_in, secs_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         values_are_bcd_ff <= 1'b1;
      end else if (csr_valid) begin
         values_are_bcd_ff <= csr_data;
      end
   end

   // per-stage ready, a stage moves when it is empty or the next one moves
   assign rdy6       = !v6_ff || rsp_tready;
   assign rdy5       = !v5_ff || rdy6;
   assign rdy4       = !v4_ff || rdy5;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign rsp_tvalid = v6_ff;
   assign rsp_tdata  = secs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
      end
   end

   // stage 1: bcd decode
   always_comb begin
      cal_in.sec  = rtcdu_pkg::decode_byte(req_tdata[rtcdu_pkg::SecIdx*8 +: 8],
                                           values_are_bcd_ff);
      cal_in.min  = rtcdu_pkg::decode_byte(req_tdata[rtcdu_pkg::MinIdx*8 +: 8],
                                           values_are_bcd_ff);
      cal_in.hour = rtcdu_pkg::decode_byte(req_tdata[rtcdu_pkg::HourIdx*8 +: 8],
                                           values_are_bcd_ff);
      cal_in.day  = rtcdu_pkg::decode_byte(req_tdata[rtcdu_pkg::DayIdx*8 +: 8],
                                           values_are_bcd_ff);
      cal_in.mon  = rtcdu_pkg::decode_byte(req_tdata[rtcdu_pkg::MonIdx*8 +: 8],
                                           values_are_bcd_ff);
      cal_in.year = rtcdu_pkg::decode_byte(req_tdata[rtcdu_pkg::YearIdx*8 +: 8],
                                           values_are_bcd_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         cal_ff <= cal_in;
      end
   end

   // stage 2: full year, march-based month, time of day
   always_comb begin
      if (cal_ff.year < rtcdu_pkg::TwoDigitMax) begin
         y_in = rtcdu_pkg::CenturyBase + {4'd0, cal_ff.year};
      end else begin
         y_in = {4'd0, cal_ff.year};
      end
      if (cal_ff.mon <= rtcdu_pkg::FebMonth) begin
         y_in  = y_in - 12'd1;
         mp_in = cal_ff.mon + rtcdu_pkg::JanShift;
      end else begin
         mp_in = cal_ff.mon - rtcdu_pkg::MarchShift;
      end
      hms_in = {12'd0, cal_ff.hour} * {8'd0, rtcdu_pkg::SecsPerHour}
             + {12'd0, cal_ff.min} * {14'd0, rtcdu_pkg::SecsPerMin}
             + {12'd0, cal_ff.sec};
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         y_ff    <= y_in;
         mp_ff   <= mp_in;
         d2_ff   <= cal_ff.day;
         hms2_ff <= hms_in;
      end
   end

   // stage 3: era and year of era, month numerator
   always_comb begin
      for (int k = 0; k < rtcdu_pkg::EraMax; k++) begin
         era_hit[k] = (y_ff >= 12'((k + 1) * 400));
      end
      era_in = rtcdu_pkg::EraWidth'($countones(era_hit));
      yoe_in = 9'(y_ff - 12'(era_in * rtcdu_pkg::EraYears));
      num_in = {8'd0, mp_ff} * {8'd0, rtcdu_pkg::MonthSpan} + rtcdu_pkg::MonthRound;
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         era3_ff <= era_in;
         yoe_ff  <= yoe_in;
         num_ff  <= num_in;
         d3_ff   <= d2_ff;
         hms3_ff <= hms2_ff;
      end
   end

   // stage 4: divide by five through reciprocal, days from era start to year
   always_comb begin
      prod_w      = num_ff * rtcdu_pkg::RecipFive;
      quot_in     = prod_w[rtcdu_pkg::RecipShift +: rtcdu_pkg::QuotWidth];
      cent_hit[0] = (yoe_ff >= rtcdu_pkg::CenturyYears);
      cent_hit[1] = (yoe_ff >= 9'(2 * rtcdu_pkg::CenturyYears));
      cent_hit[2] = (yoe_ff >= 9'(3 * rtcdu_pkg::CenturyYears));
      yterm_in    = {9'd0, yoe_ff} * {9'd0, rtcdu_pkg::DaysPerYear}
                  + {11'd0, yoe_ff[8:2]}
                  - 18'($countones(cent_hit));
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         quot_ff  <= quot_in;
         yterm_ff <= yterm_in;
         era4_ff  <= era3_ff;
         d4_ff    <= d3_ff;
         hms4_ff  <= hms3_ff;
      end
   end

   // stage 5: signed day count from epoch
   always_comb begin
      days_in = {19'd0, era4_ff} * {5'd0, rtcdu_pkg::DaysPerEra}
              + {5'd0, yterm_ff}
              + {9'd0, quot_ff}
              + {15'd0, d4_ff}
              - 23'd1
              - rtcdu_pkg::EpochShift;
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         days_ff <= days_in;
         hms5_ff <= hms4_ff;
      end
   end

   // stage 6: seconds, low 32 bits
   always_comb begin
      days_ext = {{(32 - rtcdu_pkg::DaysWidth){days_ff[rtcdu_pkg::DaysWidth-1]}}, days_ff};
      secs_in  = 32'(days_ext * rtcdu_pkg::SecsPerDay) + {12'd0, hms5_ff};
   end

   always_ff @(posedge clock) begin
      if (rdy6) begin
         secs_ff <= secs_in;
      end
   end

   a_stall_means_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && v6_ff && !rsp_tready))
      else $error("input stalled with an empty stage");

   a_word_moves_on : assert property (@(posedge clock) disable iff (reset)
      (v5_ff && rdy6) |=> v6_ff)
      else $error("word lost between last two stages");

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1_ff)
      else $error("accepted word not held in first stage");

   a_reset_bcd : assert property (@(posedge clock)
      reset |=> values_are_bcd_ff)
      else $error("bcd mode not set by reset");

endmodule
